@@ sv/raster_to_tiled_texture_converter_assert.svh @@
// Assertion helpers shared by the converter RTL.
// Every check is clocked on clk_i and masked while rst_ni is low.
`ifndef RASTER_TO_TILED_TEXTURE_CONVERTER_ASSERT_SVH
`define RASTER_TO_TILED_TEXTURE_CONVERTER_ASSERT_SVH

// Flag a condition that must never be seen.
`define RTTC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("rttc: forbidden condition");

// Flag a consequent that does not hold in the same cycle as its antecedent.
`define RTTC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rttc: implication failed");

`endif

@@ sv/rttc_pkg.sv @@
`default_nettype none

package rttc_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned TILE_SIDE     = 4;
  localparam int unsigned DIM_W         = 11;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned PIX_W         = 3 * BYTE_W;
  localparam int unsigned PAIR_W        = 2 * BYTE_W;
  localparam int unsigned WORD_W        = TILE_SIDE * PAIR_W;
  localparam int unsigned CFG_IDX_W     = 2;
  // tile column index, wide enough for the largest supported line width
  localparam int unsigned TIDX_W        = 10;
  localparam int unsigned ROW_SEL_W     = $clog2(TILE_SIDE);
  localparam int unsigned LANE_W        = $clog2(TILE_SIDE);
  localparam int unsigned WORD_CNT_W    = 3;
  localparam int unsigned JOBQ_DEPTH    = 2;
  localparam int unsigned OUTQ_DEPTH    = 4;

  localparam logic [ROW_SEL_W-1:0]  LAST_ROW       = ROW_SEL_W'(TILE_SIDE - 1);
  localparam logic [LANE_W-1:0]     LAST_LANE      = LANE_W'(TILE_SIDE - 1);
  localparam logic [WORD_CNT_W-1:0] LAST_WORD_RGBA = WORD_CNT_W'(2 * TILE_SIDE - 1);
  localparam logic [WORD_CNT_W-1:0] LAST_WORD_5A3  = WORD_CNT_W'(TILE_SIDE - 1);
  localparam logic [BYTE_W-1:0]     ALPHA_OPAQUE   = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_PIXEL_FORMAT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    FMT_RGBA8  = 1'b0,
    FMT_RGB5A3 = 1'b1
  } pix_fmt_e;

  // one finished tile waiting for readout
  typedef struct packed {
    logic [TIDX_W-1:0] tidx;
    pix_fmt_e          fmt;
    logic              last_tile;
  } tile_job_t;

  // line store write request
  typedef struct packed {
    logic                 en;
    logic [ROW_SEL_W-1:0] row;
    logic [TIDX_W-1:0]    tidx;
    logic [LANE_W-1:0]    lane;
    logic [PIX_W-1:0]     pix;
  } store_wr_t;

  typedef struct packed {
    logic push;
    logic full;
    logic empty;
  } jobq_stat_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              tile_end;
    logic              frame_end;
  } out_item_t;

  // Build the 16-bit pair that one pixel contributes to a tile word.
  function automatic logic [PAIR_W-1:0] pack_pair(input logic [PIX_W-1:0] px,
                                                   input pix_fmt_e fmt,
                                                   input logic color_half);
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [PAIR_W-1:0] pair;
    b0 = px[BYTE_W-1:0];
    b1 = px[2*BYTE_W-1:BYTE_W];
    b2 = px[3*BYTE_W-1:2*BYTE_W];
    if (fmt == FMT_RGB5A3) begin
      pair = {1'b1, b1[BYTE_W-2:0], b0};
    end else if (!color_half) begin
      pair = {ALPHA_OPAQUE, b2};
    end else begin
      pair = {b1, b0};
    end
    return pair;
  endfunction

endpackage

`default_nettype wire

@@ sv/rttc_pix_if.sv @@
`default_nettype none

interface rttc_pix_if;
  import rttc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_zero;
  logic [BYTE_W-1:0] byte_one;
  logic [BYTE_W-1:0] byte_two;

  modport source (output valid, byte_zero, byte_one, byte_two, input ready);
  modport sink   (input valid, byte_zero, byte_one, byte_two, output ready);
endinterface

`default_nettype wire

@@ sv/rttc_tile_if.sv @@
`default_nettype none

interface rttc_tile_if;
  import rttc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] tile_word;
  logic              tile_end;
  logic              frame_end;

  modport source (output valid, tile_word, tile_end, frame_end, input ready);
  modport sink   (input valid, tile_word, tile_end, frame_end, output ready);
endinterface

`default_nettype wire

@@ sv/rttc_cfg_if.sv @@
`default_nettype none

interface rttc_cfg_if;
  import rttc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/rttc_front.sv @@
`default_nettype none

module rttc_front #(
  parameter int unsigned MAX_WIDTH = rttc_pkg::MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rttc_pix_if.sink              pix_i,
  rttc_cfg_if.sink              cfg_i,
  input  logic                  jobs_pending_i,
  input  logic                  job_full_i,
  output rttc_pkg::store_wr_t   wr_o,
  output logic                  job_push_o,
  output rttc_pkg::tile_job_t   job_o
);
  import rttc_pkg::*;

  localparam int unsigned MaxW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ColW = (MaxW > DIM_W) ? MaxW : DIM_W;

  logic [DIM_W-1:0] width_q, height_q;
  pix_fmt_e         fmt_q;
  logic [DIM_W-1:0] col_q, col_d;
  logic [DIM_W-1:0] row_q, row_d;

  logic             frame_empty;
  logic [ColW-1:0]  col_x, lim, col_tiles, col_tidx;
  logic [DIM_W-1:0] row_tiles, row_tidx;
  logic             in_store, tile_here, last_tile, hazard, accept;
  logic             cfg_hit;
  logic [DIM_W:0]   col_inc, row_inc;

  // classify the current raster position
  always_comb begin
    frame_empty = (width_q == '0) || (height_q == '0);
    col_x       = ColW'(col_q);
    in_store    = col_x < ColW'(MAX_WIDTH);
    lim         = (ColW'(width_q) < ColW'(MAX_WIDTH)) ? ColW'(width_q) : ColW'(MAX_WIDTH);
    col_tiles   = lim >> ROW_SEL_W;
    col_tidx    = col_x >> LANE_W;
    row_tiles   = height_q >> ROW_SEL_W;
    row_tidx    = row_q >> ROW_SEL_W;
    tile_here   = !frame_empty && (row_q[ROW_SEL_W-1:0] == LAST_ROW) &&
                  (col_q[LANE_W-1:0] == LAST_LANE) &&
                  (col_tidx < col_tiles) && (row_tidx < row_tiles);
    last_tile   = (col_tidx + ColW'(1) == col_tiles) && (row_tidx + DIM_W'(1) == row_tiles);
  end

  // hold new rows back until tiles still in flight have been read out
  assign hazard      = jobs_pending_i && (row_q[ROW_SEL_W-1:0] != LAST_ROW);
  assign pix_i.ready = !hazard && !(tile_here && job_full_i);
  assign accept      = pix_i.valid && pix_i.ready;

  // drive the line store write
  always_comb begin
    wr_o.en   = accept && !frame_empty && in_store;
    wr_o.row  = row_q[ROW_SEL_W-1:0];
    wr_o.tidx = TIDX_W'(col_tidx);
    wr_o.lane = col_q[LANE_W-1:0];
    wr_o.pix  = {pix_i.byte_two, pix_i.byte_one, pix_i.byte_zero};
  end

  // hand finished tiles to the back end
  assign job_push_o     = accept && tile_here;
  assign job_o.tidx     = TIDX_W'(col_tidx);
  assign job_o.fmt      = fmt_q;
  assign job_o.last_tile = last_tile;

  // flag a write to a known register
  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_PIXEL_FORMAT: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // advance the raster counters; a known register write restarts the frame
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    col_inc = {1'b0, col_q} + (DIM_W + 1)'(1);
    row_inc = {1'b0, row_q} + (DIM_W + 1)'(1);
    if (accept && !frame_empty) begin
      if (col_inc >= {1'b0, width_q}) begin
        col_d = '0;
        row_d = (row_inc >= {1'b0, height_q}) ? '0 : row_inc[DIM_W-1:0];
      end else begin
        col_d = col_inc[DIM_W-1:0];
      end
    end
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end
  end

  assign cfg_i.ready = 1'b1;

  // take register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      fmt_q    <= FMT_RGBA8;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_IMAGE_WIDTH: begin
            width_q <= cfg_i.data;
          end
          REG_IMAGE_HEIGHT: begin
            height_q <= cfg_i.data;
          end
          REG_PIXEL_FORMAT: begin
            fmt_q <= pix_fmt_e'(cfg_i.data[0]);
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/rttc_jobq.sv @@
`default_nettype none

module rttc_jobq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rttc_pkg::tile_job_t   job_i,
  input  logic                  pop_i,
  output rttc_pkg::tile_job_t   job_o,
  output rttc_pkg::jobq_stat_t  stat_o
);
  import rttc_pkg::*;

  localparam int unsigned PtrW = $clog2(JOBQ_DEPTH);
  localparam int unsigned CntW = $clog2(JOBQ_DEPTH + 1);

  tile_job_t         slot_q [JOBQ_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign job_o        = slot_q[rd_ptr_q];
  assign stat_o.push  = push_i;
  assign stat_o.full  = cnt_q == CntW'(JOBQ_DEPTH);
  assign stat_o.empty = cnt_q == '0;

  // store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/rttc_line_store.sv @@
`default_nettype none

module rttc_line_store #(
  parameter int unsigned MAX_WIDTH = rttc_pkg::MAX_WIDTH_DEF
) (
  input  logic                                           clk_i,
  input  rttc_pkg::store_wr_t                            wr_i,
  input  logic                                           rd_en_i,
  input  logic [rttc_pkg::ROW_SEL_W-1:0]                 rd_row_i,
  input  logic [rttc_pkg::TIDX_W-1:0]                    rd_tidx_i,
  output logic [rttc_pkg::TILE_SIDE*rttc_pkg::PIX_W-1:0] rd_data_o
);
  import rttc_pkg::*;

  localparam int unsigned TileCols = (MAX_WIDTH + TILE_SIDE - 1) / TILE_SIDE;
  localparam int unsigned TW       = (TileCols > 1) ? $clog2(TileCols) : 1;
  localparam int unsigned AddrW    = ROW_SEL_W + TW;
  localparam int unsigned Depth    = 2 ** AddrW;

  logic [AddrW-1:0] wr_addr, rd_addr;

  assign wr_addr = {wr_i.row, wr_i.tidx[TW-1:0]};
  assign rd_addr = {rd_row_i, rd_tidx_i[TW-1:0]};

  // one memory per pixel lane; a read returns a whole tile row
  for (genvar l = 0; l < TILE_SIDE; l++) begin : g_lane
    logic [PIX_W-1:0] mem [Depth];
    logic [PIX_W-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (wr_i.en && (wr_i.lane == LANE_W'(l))) begin
        mem[wr_addr] <= wr_i.pix;
      end
      if (rd_en_i) begin
        rd_q <= mem[rd_addr];
      end
    end

    // leftmost pixel sits in the top lane
    assign rd_data_o[(TILE_SIDE - l)*PIX_W-1 -: PIX_W] = rd_q;
  end

endmodule

`default_nettype wire

@@ sv/rttc_back.sv @@
`default_nettype none

module rttc_back (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  rttc_pkg::tile_job_t                            job_i,
  input  logic                                           job_empty_i,
  output logic                                           job_pop_o,
  output logic                                           busy_o,
  output logic                                           rd_en_o,
  output logic [rttc_pkg::ROW_SEL_W-1:0]                 rd_row_o,
  output logic [rttc_pkg::TIDX_W-1:0]                    rd_tidx_o,
  input  logic [rttc_pkg::TILE_SIDE*rttc_pkg::PIX_W-1:0] rd_data_i,
  rttc_tile_if.source                                    tile_o
);
  import rttc_pkg::*;

  localparam int unsigned QPtrW = $clog2(OUTQ_DEPTH);
  localparam int unsigned QCntW = $clog2(OUTQ_DEPTH + 1);

  logic                  active_q;
  tile_job_t             job_q;
  logic [WORD_CNT_W-1:0] k_q;

  logic                  rd_valid_q;
  logic [WORD_CNT_W-1:0] rd_k_q;
  pix_fmt_e              rd_fmt_q;
  logic                  rd_tend_q, rd_fend_q;

  out_item_t             outq_q [OUTQ_DEPTH];
  logic [QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]      cnt_q;

  logic [WORD_CNT_W-1:0] words_last;
  logic                  credit_ok, issue, issue_last, out_pop;
  out_item_t             fmt_item;

  // issue one line store read per word while output space is reserved
  assign words_last = (job_q.fmt == FMT_RGB5A3) ? LAST_WORD_5A3 : LAST_WORD_RGBA;
  assign credit_ok  = (QCntW'(cnt_q) + QCntW'(rd_valid_q)) < QCntW'(OUTQ_DEPTH);
  assign issue      = active_q && credit_ok;
  assign issue_last = issue && (k_q == words_last);
  assign job_pop_o  = !job_empty_i && (!active_q || issue_last);
  assign busy_o     = active_q;

  assign rd_en_o    = issue;
  assign rd_row_o   = k_q[ROW_SEL_W-1:0];
  assign rd_tidx_o  = job_q.tidx;

  // walk the words of the current tile
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      k_q        <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= issue;
      if (job_pop_o) begin
        active_q <= 1'b1;
        k_q      <= '0;
      end else if (issue_last) begin
        active_q <= 1'b0;
      end else if (issue) begin
        k_q <= k_q + WORD_CNT_W'(1);
      end
    end
  end

  // carry word attributes alongside the read
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (issue) begin
      rd_k_q    <= k_q;
      rd_fmt_q  <= job_q.fmt;
      rd_tend_q <= issue_last;
      rd_fend_q <= issue_last && job_q.last_tile;
    end
  end

  // pack the tile row into a 64-bit word
  always_comb begin
    fmt_item.tile_end  = rd_tend_q;
    fmt_item.frame_end = rd_fend_q;
    for (int x = 0; x < TILE_SIDE; x++) begin
      fmt_item.word[(TILE_SIDE - x)*PAIR_W-1 -: PAIR_W] =
        pack_pair(rd_data_i[(TILE_SIDE - x)*PIX_W-1 -: PIX_W], rd_fmt_q,
                  rd_k_q[WORD_CNT_W-1]);
    end
  end

  // output queue decouples the read pipe from the consumer
  assign out_pop          = tile_o.valid && tile_o.ready;
  assign tile_o.valid     = cnt_q != '0;
  assign tile_o.tile_word = outq_q[rd_ptr_q].word;
  assign tile_o.tile_end  = outq_q[rd_ptr_q].tile_end;
  assign tile_o.frame_end = outq_q[rd_ptr_q].frame_end;

  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      outq_q[wr_ptr_q] <= fmt_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (rd_valid_q) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      case ({rd_valid_q, out_pop})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/raster_to_tiled_texture_converter.sv @@
// Channel   Dir  Handshake     Payload
// pix_i     in   valid/ready   byte_zero, byte_one, byte_two (8 bits each)
// tile_o    out  valid/ready   tile_word (64), tile_end, frame_end
// cfg_i     in   valid/ready   index (2), data (11); ready is always high
//
// A pixel is taken every cycle unless one of the stalls below holds; a completed
// 4x4 tile is read out of the line store one tile row per cycle while the output
// queue has room, giving eight words (RGBA8) or four (RGB5A3) through the single
// read port; read data is registered before it enters the tile_o output queue.
// The first pixel of a new 4-row group stalls until all queued tiles are read.
// A pixel that completes a tile also stalls while the two-entry tile queue is full.
// Reset clears counters and registers; the line store has no clearing pass.
`default_nettype none

`include "raster_to_tiled_texture_converter_assert.svh"

module raster_to_tiled_texture_converter #(
  parameter int unsigned MAX_WIDTH = rttc_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rttc_pix_if.sink    pix_i,
  rttc_tile_if.source tile_o,
  rttc_cfg_if.sink    cfg_i
);
  import rttc_pkg::*;

  store_wr_t                        store_wr;
  tile_job_t                        push_job, head_job;
  jobq_stat_t                       jobq_stat;
  logic                             job_push, job_pop, back_busy, pending;
  logic                             rd_en;
  logic [ROW_SEL_W-1:0]             rd_row;
  logic [TIDX_W-1:0]                rd_tidx;
  logic [TILE_SIDE*PIX_W-1:0]       rd_data;

  assign pending = !jobq_stat.empty || back_busy;

  rttc_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix_i          (pix_i),
    .cfg_i          (cfg_i),
    .jobs_pending_i (pending),
    .job_full_i     (jobq_stat.full),
    .wr_o           (store_wr),
    .job_push_o     (job_push),
    .job_o          (push_job)
  );

  rttc_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .wr_i      (store_wr),
    .rd_en_i   (rd_en),
    .rd_row_i  (rd_row),
    .rd_tidx_i (rd_tidx),
    .rd_data_o (rd_data)
  );

  rttc_jobq u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .job_i  (push_job),
    .pop_i  (job_pop),
    .job_o  (head_job),
    .stat_o (jobq_stat)
  );

  rttc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_empty_i (jobq_stat.empty),
    .job_pop_o   (job_pop),
    .busy_o      (back_busy),
    .rd_en_o     (rd_en),
    .rd_row_o    (rd_row),
    .rd_tidx_o   (rd_tidx),
    .rd_data_i   (rd_data),
    .tile_o      (tile_o)
  );

  // tile queue never overflows
  `RTTC_ASSERT_NEVER(a_jobq_no_overflow, jobq_stat.push && jobq_stat.full)
  // rows that pending tiles still need are never overwritten
  `RTTC_ASSERT_IMPL(a_store_guard, store_wr.en && (store_wr.row != LAST_ROW), !pending)
  // the frame marker only rides on a tile's last word
  `RTTC_ASSERT_IMPL(a_frame_on_tile_end, tile_o.valid && tile_o.frame_end, tile_o.tile_end)

endmodule

`default_nettype wire

@@ tb/rttc_tile_checker.sv @@
// Watches the pixel, register and tile channels, keeps its own line store and
// frame position, and compares every tile word with the one it predicts.
module rttc_tile_checker #(
  parameter int unsigned MAX_WIDTH = rttc_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rttc_pix_if         pix_i,
  rttc_tile_if        tile_i,
  rttc_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned words_pending_o
);
  import rttc_pkg::*;

  logic [PIX_W-1:0] line_store [TILE_SIDE*MAX_WIDTH];
  logic [DIM_W-1:0] img_width;
  logic [DIM_W-1:0] img_height;
  pix_fmt_e         img_format;
  logic [DIM_W-1:0] col_pos;
  logic [DIM_W-1:0] row_pos;
  out_item_t        tile_words_due [$];

  // Store one pixel, queue the words of the tile it completes, advance.
  task automatic predict_tiles(input logic [PIX_W-1:0] px);
    int unsigned       col;
    int unsigned       row;
    int unsigned       span;
    int unsigned       tiles_w;
    int unsigned       tiles_h;
    int unsigned       base;
    int unsigned       n_words;
    logic [PIX_W-1:0]  src;
    logic [PAIR_W-1:0] pair;
    logic [WORD_W-1:0] word;
    out_item_t         item;
    if (img_width == 0 || img_height == 0) begin
      return;
    end
    col = col_pos;
    row = row_pos;
    // columns past the store width are counted but not kept
    if (col < MAX_WIDTH) begin
      line_store[(row % TILE_SIDE) * MAX_WIDTH + col] = px;
    end
    span    = (img_width < MAX_WIDTH) ? img_width : MAX_WIDTH;
    tiles_w = span / TILE_SIDE * TILE_SIDE;
    tiles_h = img_height / TILE_SIDE * TILE_SIDE;
    if (row % TILE_SIDE == TILE_SIDE - 1 && col % TILE_SIDE == TILE_SIDE - 1 &&
        col < tiles_w && row < tiles_h) begin
      base    = col - (TILE_SIDE - 1);
      n_words = (img_format == FMT_RGB5A3) ? TILE_SIDE : 2 * TILE_SIDE;
      for (int k = 0; k < n_words; k++) begin
        word = '0;
        for (int x = 0; x < TILE_SIDE; x++) begin
          src = line_store[(k % TILE_SIDE) * MAX_WIDTH + base + x];
          if (img_format == FMT_RGB5A3) begin
            pair = {1'b1, src[2*BYTE_W-2:BYTE_W], src[BYTE_W-1:0]};
          end else if (k < TILE_SIDE) begin
            pair = {ALPHA_OPAQUE, src[3*BYTE_W-1:2*BYTE_W]};
          end else begin
            pair = src[2*BYTE_W-1:0];
          end
          word = {word[WORD_W-PAIR_W-1:0], pair};
        end
        item.word      = word;
        item.tile_end  = (k == n_words - 1);
        item.frame_end = item.tile_end && (col == tiles_w - 1) && (row == tiles_h - 1);
        tile_words_due.push_back(item);
      end
    end
    col++;
    if (col >= img_width) begin
      col = 0;
      row++;
      if (row >= img_height) begin
        row = 0;
      end
    end
    col_pos = DIM_W'(col);
    row_pos = DIM_W'(row);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_item_t due;
    logic      restart;
    if (!rst_ni) begin
      img_width  = '0;
      img_height = '0;
      img_format = FMT_RGBA8;
      col_pos    = '0;
      row_pos    = '0;
      tile_words_due.delete();
      fail_count_o    <= 0;
      words_pending_o <= 0;
    end else begin
      // compare the delivered word with the oldest prediction
      if (tile_i.valid && tile_i.ready) begin
        if (tile_words_due.size() == 0) begin
          $display("%0t: unexpected tile word: expected none, got %h/%b/%b", $time,
                   tile_i.tile_word, tile_i.tile_end, tile_i.frame_end);
          fail_count_o <= fail_count_o + 1;
        end else begin
          due = tile_words_due.pop_front();
          if (due.word !== tile_i.tile_word || due.tile_end !== tile_i.tile_end ||
              due.frame_end !== tile_i.frame_end) begin
            $display("%0t: tile word mismatch: expected %h/%b/%b, got %h/%b/%b", $time,
                     due.word, due.tile_end, due.frame_end,
                     tile_i.tile_word, tile_i.tile_end, tile_i.frame_end);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // a write to a known register restarts the frame
      if (cfg_i.valid && cfg_i.ready) begin
        restart = 1'b1;
        case (cfg_i.index)
          REG_IMAGE_WIDTH:  img_width  = cfg_i.data;
          REG_IMAGE_HEIGHT: img_height = cfg_i.data;
          REG_PIXEL_FORMAT: img_format = pix_fmt_e'(cfg_i.data[0]);
          default:          restart    = 1'b0;
        endcase
        if (restart) begin
          col_pos = '0;
          row_pos = '0;
        end
      end
      if (pix_i.valid && pix_i.ready) begin
        predict_tiles({pix_i.byte_two, pix_i.byte_one, pix_i.byte_zero});
      end
      words_pending_o <= tile_words_due.size();
    end
  end

endmodule

@@ tb/raster_to_tiled_texture_converter_tb.sv @@
// Stimulus and verdict for the tiling converter; prediction lives in the checker.
module raster_to_tiled_texture_converter_tb;
  import rttc_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 64;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  typedef enum int unsigned {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_LIGHT
  } stall_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        hold_off_req = 1'b0;
  int unsigned fail_count;
  int unsigned words_pending;
  int unsigned quiet_cycles  = 0;
  int unsigned burst_left    = 0;
  int unsigned random_pixels = 0;

  rttc_pix_if  pix_bus ();
  rttc_tile_if tile_bus ();
  rttc_cfg_if  cfg_bus ();

  raster_to_tiled_texture_converter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_bus),
    .tile_o (tile_bus),
    .cfg_i  (cfg_bus)
  );

  rttc_tile_checker tile_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pix_i           (pix_bus),
    .tile_i          (tile_bus),
    .cfg_i           (cfg_bus),
    .fail_count_o    (fail_count),
    .words_pending_o (words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the tile side on a changing pattern, or hold it off once on request.
  initial begin
    stall_mode_e mode;
    int unsigned span;
    logic        hold_done;
    hold_done = 1'b0;
    tile_bus.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        tile_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        mode = stall_mode_e'($urandom_range(0, 3));
        span = $urandom_range(8, 60);
        while (span != 0 && !(hold_off_req && !hold_done)) begin
          case (mode)
            STALL_NONE:  tile_bus.ready <= 1'b1;
            STALL_HALF:  tile_bus.ready <= 1'($urandom_range(0, 1));
            STALL_HEAVY: tile_bus.ready <= ($urandom_range(0, 3) == 0);
            default:     tile_bus.ready <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk_i);
          span--;
        end
      end
    end
  end

  // End the run if no channel moves for too long.
  always @(posedge clk_i) begin
    if ((pix_bus.valid && pix_bus.ready) || (tile_bus.valid && tile_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("raster_to_tiled_texture_converter_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // Offer one pixel in bursts with random gaps; return once it is taken.
  task automatic offer_pixel(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                             input logic [BYTE_W-1:0] b2);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      if (gap != 0) begin
        pix_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    pix_bus.valid     <= 1'b1;
    pix_bus.byte_zero <= b0;
    pix_bus.byte_one  <= b1;
    pix_bus.byte_two  <= b2;
    @(posedge clk_i);
    while (!pix_bus.ready) @(posedge clk_i);
    burst_left--;
  endtask

  // Drop valid, wait out every predicted word, then let the pipeline empty.
  task automatic settle();
    pix_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leave valid high so back-to-back writes follow each other directly.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
  endtask

  task automatic set_format(input int unsigned width, input int unsigned height,
                            input pix_fmt_e fmt);
    write_reg(REG_IMAGE_WIDTH, DIM_W'(width));
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(height));
    write_reg(REG_PIXEL_FORMAT, {(DIM_W-1)'($urandom), fmt});
    cfg_bus.valid <= 1'b0;
  endtask

  // Configure, stream random pixels, sometimes pausing mid-frame until drained.
  task automatic run_frame(input int unsigned width, input int unsigned height,
                           input pix_fmt_e fmt, input int unsigned count);
    int unsigned split;
    set_format(width, height, fmt);
    split = ($urandom_range(0, 3) == 0) ? $urandom_range(0, count) : count;
    repeat (split) offer_pixel(rand_byte(), rand_byte(), rand_byte());
    if (split != count) begin
      settle();
      repeat (count - split) offer_pixel(rand_byte(), rand_byte(), rand_byte());
    end
    settle();
  endtask

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return $urandom_range(1, 3);
      default: return $urandom_range(1, 3) * TILE_SIDE +
                      ($urandom_range(0, 1) ? $urandom_range(1, 3) : 0);
    endcase
  endfunction

  function automatic int unsigned pick_height();
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return $urandom_range(1, 3);
      default: return $urandom_range(1, 2) * TILE_SIDE +
                      ($urandom_range(0, 1) ? $urandom_range(1, 3) : 0);
    endcase
  endfunction

  initial begin
    int unsigned       w;
    int unsigned       h;
    int unsigned       n;
    int unsigned       full;
    pix_fmt_e          fmt;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    rst_ni            = 1'b0;
    pix_bus.valid     = 1'b0;
    pix_bus.byte_zero = '0;
    pix_bus.byte_one  = '0;
    pix_bus.byte_two  = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // dimensions are zero after reset: pixels must vanish
    repeat (2) offer_pixel(8'hFF, 8'hFF, 8'hFF);
    settle();

    // a zero height alone still blocks every tile
    write_reg(REG_IMAGE_WIDTH, DIM_W'(TILE_SIDE));
    cfg_bus.valid <= 1'b0;
    offer_pixel(8'h00, 8'h00, 8'h00);
    settle();

    // start a 4x4 frame, then restart it with a format change
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(TILE_SIDE));
    write_reg(REG_PIXEL_FORMAT, {(DIM_W-1)'(0), FMT_RGBA8});
    cfg_bus.valid <= 1'b0;
    repeat (5) offer_pixel(rand_byte(), rand_byte(), rand_byte());
    settle();
    write_reg(REG_PIXEL_FORMAT, {(DIM_W-1)'('1), FMT_RGB5A3});
    cfg_bus.valid <= 1'b0;

    // extreme bytes; a write to the unused index mid-frame must not restart it
    for (int i = 0; i < 16; i++) begin
      if (i == 8) begin
        settle();
        write_reg(REG_UNUSED, '1);
        cfg_bus.valid <= 1'b0;
      end
      b0 = (i < 8) ? {BYTE_W{i[0]}} : BYTE_W'(i * 8'h11);
      case (i[1:0])
        2'd0:    b1 = 8'h00;
        2'd1:    b1 = 8'h7F;
        2'd2:    b1 = 8'h80;
        default: b1 = 8'hFF;
      endcase
      offer_pixel(b0, b1, {BYTE_W{i[2]}});
    end
    settle();

    // hold the tile side off while a tile-heavy frame streams in
    hold_off_req = 1'b1;
    run_frame(16, 8, FMT_RGBA8, 128);

    // random frames: mostly whole frames with spill into the next, some cut short
    while (random_pixels < RANDOM_PIXELS) begin
      w    = pick_width();
      h    = pick_height();
      fmt  = pix_fmt_e'($urandom_range(0, 1));
      full = w * h;
      if (full == 0) begin
        n = $urandom_range(1, 4);
      end else begin
        case ($urandom_range(0, 9))
          0:       n = $urandom_range(1, 6);
          1, 2:    n = $urandom_range(1, full);
          default: n = full + $urandom_range(0, w);
        endcase
        random_pixels += n;
      end
      run_frame(w, h, fmt, n);
    end

    // register extremes, including a width past the line store
    run_frame(MAX_WIDTH_DEF + 6, TILE_SIDE, pix_fmt_e'($urandom_range(0, 1)), 24);
    run_frame(2047, 2047, FMT_RGBA8, 24);
    run_frame(TILE_SIDE, 2047, FMT_RGB5A3, 40);

    if (fail_count == 0 && words_pending == 0) begin
      $display("raster_to_tiled_texture_converter_tb: PASS");
    end else begin
      $display("raster_to_tiled_texture_converter_tb: FAIL");
    end
    $finish;
  end

endmodule
